// ===== rtl/core/rgbw_pkg.sv =====
// Package for the RGBW fade pixel blender: widths, register indexes and helpers.
// Used by rgbw_divider.sv and rgbw_fade_pixel_blender.sv.
package rgbw_pkg;
   localparam int ChanW  = 8;
   localparam int NumCh  = 4;
   localparam int SumW   = 12;          // 12*255 = 3060
   localparam int QuoW   = 8;
   localparam int ProgW  = 17;
   localparam logic [ProgW-1:0] ProgOne = 17'h10000;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 32;
   localparam logic [CsrIdxW-1:0] CsrTarget = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrLimit  = 1'b1;

   typedef logic [NumCh-1:0][ChanW-1:0] color_type;

   function automatic logic [SumW-1:0] weighted_sum(input color_type c);
      logic [SumW-1:0] s;
      s = SumW'(5 * c[3]) + SumW'(2 * c[2]) + SumW'(3 * c[1]) + SumW'(2 * c[0]);
      return s;
   endfunction
endpackage

// ===== rtl/core/rgbw_fade_pixel_blender.sv =====
// Top level of the RGBW fade pixel blender: brightness limit, divide, blend.
// Depends on rgbw_pkg and rgbw_divider.
//
//  channel  | direction | tdata / tuser
//  req_     | in        | tdata[31:0] start_color, [48:32] progress
//  rsp_     | out       | tdata[31:0] blended_color
//  csr_     | in        | idx 0 target_color, idx 1 limit_mode
//
// One pixel per clock while the output is not stalled; depth set by the 8-stage divider.
// Synchronous reset clears valid bits and csr registers. A stalled output freezes
// the whole pipeline; nothing is dropped or repeated.
module rgbw_fade_pixel_blender (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // [31:0] start_color, [48:32] progress
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] blended_color
   input  logic        csr_we,
   input  logic [rgbw_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [rgbw_pkg::CsrDataW-1:0] csr_wdata
);
   localparam int D  = rgbw_pkg::QuoW;
   localparam int NS = D + 4;          // total stages
   localparam int NW = rgbw_pkg::ChanW + rgbw_pkg::SumW;

   logic [31:0] target_ff;
   logic        limit_ff;
   logic [NS-1:0] vld_ff;
   logic advance;

   assign advance    = !vld_ff[NS-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         limit_ff  <= 1'b0;
         vld_ff    <= '0;
      end else begin
         if (csr_we && csr_index == rgbw_pkg::CsrTarget) target_ff <= csr_wdata;
         if (csr_we && csr_index == rgbw_pkg::CsrLimit)  limit_ff  <= csr_wdata[0];
         if (advance) vld_ff <= {vld_ff[NS-2:0], req_tvalid};
      end
   end

   // stage 1: input capture, clamp progress, weighted sums
   rgbw_pkg::color_type start_ff [NS-1];
   logic [16:0] prog_ff [NS-1];
   logic [rgbw_pkg::SumW-1:0] ssum_ff, tsum_ff;
   logic scale_ff [NS-1];
   logic [16:0] prog_in;
   rgbw_pkg::color_type start_in;
   assign start_in = req_tdata[31:0];
   assign prog_in  = (req_tdata[48:32] > rgbw_pkg::ProgOne) ? rgbw_pkg::ProgOne
                                                            : req_tdata[48:32];
   always_ff @(posedge clock) begin
      if (advance) begin
         start_ff[0] <= start_in;
         prog_ff[0]  <= prog_in;
         ssum_ff     <= rgbw_pkg::weighted_sum(start_in);
         tsum_ff     <= rgbw_pkg::weighted_sum(target_ff);
      end
   end

   // stage 2: decide, form products
   rgbw_pkg::color_type tgt;
   assign tgt = target_ff;
   logic [NW-1:0] prod_ff [rgbw_pkg::NumCh];
   logic [rgbw_pkg::SumW-1:0] den_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         start_ff[1] <= start_ff[0];
         prog_ff[1]  <= prog_ff[0];
         scale_ff[1] <= limit_ff && (ssum_ff < tsum_ff);
         den_ff      <= (tsum_ff == '0) ? rgbw_pkg::SumW'(1) : tsum_ff;
         for (int c = 0; c < rgbw_pkg::NumCh; c++)
            prod_ff[c] <= NW'(tgt[c]) * NW'(ssum_ff);
      end
   end
   assign scale_ff[0] = 1'b0;

   rgbw_pkg::color_type quo;
   for (genvar c = 0; c < rgbw_pkg::NumCh; c++) begin : g_div
      rgbw_divider u_div (
         .clock(clock), .advance(advance),
         .num(prod_ff[c]), .den(den_ff), .quo(quo[c]));
   end

   // delay line alongside divider
   for (genvar s = 2; s < D + 2; s++) begin : g_dly
      always_ff @(posedge clock) begin
         if (advance) begin
            start_ff[s] <= start_ff[s-1];
            prog_ff[s]  <= prog_ff[s-1];
            scale_ff[s] <= scale_ff[s-1];
         end
      end
   end

   // stage D+3: multiply
   rgbw_pkg::color_type endc;
   assign endc = scale_ff[D+1] ? quo : target_ff;
   logic [24:0] pa_ff [rgbw_pkg::NumCh];
   logic [24:0] pb_ff [rgbw_pkg::NumCh];
   logic [16:0] inv;
   assign inv = rgbw_pkg::ProgOne - prog_ff[D+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < rgbw_pkg::NumCh; c++) begin
            pa_ff[c] <= 25'(inv) * 25'(start_ff[D+1][c]);
            pb_ff[c] <= 25'(prog_ff[D+1]) * 25'(endc[c]);
         end
      end
   end

   // stage D+4: add and shift
   logic [31:0] out_ff;
   logic [24:0] sum_c [rgbw_pkg::NumCh];
   always_comb begin
      for (int c = 0; c < rgbw_pkg::NumCh; c++) sum_c[c] = pa_ff[c] + pb_ff[c];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < rgbw_pkg::NumCh; c++) out_ff[c*8 +: 8] <= sum_c[c][23:16];
      end
   end
   assign rsp_tdata = out_ff;

   logic unused_ok;
   assign unused_ok = ^{req_tdata[55:49], start_ff[D+2], prog_ff[D+2], scale_ff[D+2],
                        sum_c[0][24], sum_c[1][24], sum_c[2][24], sum_c[3][24]};
endmodule

// ===== rtl/core/rgbw_divider.sv =====
// Pipelined restoring divider: quotient of (ch*ssum)/tsum, known to fit 8 bits
// since ssum < tsum. One quotient bit per stage. Depends on rgbw_pkg.
module rgbw_divider (
   input  logic                     clock,
   input  logic                     advance,
   input  logic [rgbw_pkg::ChanW+rgbw_pkg::SumW-1:0] num,
   input  logic [rgbw_pkg::SumW-1:0] den,
   output logic [rgbw_pkg::QuoW-1:0] quo
);
   localparam int N  = rgbw_pkg::QuoW;
   localparam int NW = rgbw_pkg::ChanW + rgbw_pkg::SumW;
   localparam int RW = rgbw_pkg::SumW + 1;

   logic [NW-1:0] rem_ff [N+1];
   logic [rgbw_pkg::SumW-1:0] den_ff [N+1];
   logic [N-1:0] q_ff [N+1];
   logic [NW-1:0] rem_in [N];
   logic [N-1:0] q_in [N];

   always_comb begin
      rem_ff[0] = num;
      den_ff[0] = den;
      q_ff[0]   = '0;
   end

   for (genvar i = 0; i < N; i++) begin : g_st
      localparam int Sh = N - 1 - i;
      logic [NW+N-1:0] dsh;
      always_comb begin
         dsh = (NW+N)'(den_ff[i]) << Sh;
         if ({{N{1'b0}}, rem_ff[i]} >= dsh) begin
            rem_in[i] = rem_ff[i] - NW'(dsh);
            q_in[i]   = q_ff[i] | (N'(1) << Sh);
         end else begin
            rem_in[i] = rem_ff[i];
            q_in[i]   = q_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1] <= rem_in[i];
            den_ff[i+1] <= den_ff[i];
            q_ff[i+1]   <= q_in[i];
         end
      end
   end

   assign quo = q_ff[N];
   logic unused_ok;
   assign unused_ok = ^{rem_ff[N], den_ff[N], RW'(0)};
endmodule

// ===== test/rgbw_blend_checker.sv =====
// Checker for the RGBW fade pixel blender: predicts each blended color and compares.
// Depends on rgbw_pkg; watches the req_, rsp_ and csr_ channels of the block.
module rgbw_blend_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [rgbw_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [rgbw_pkg::CsrDataW-1:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] target_reg;
   logic        limit_reg;
   logic [31:0] expected_colors[$];

   function automatic int unsigned brightness(input logic [31:0] c);
      return 5 * c[31:24] + 2 * c[23:16] + 3 * c[15:8] + 2 * c[7:0];
   endfunction

   function automatic logic [31:0] predict_blend(input logic [31:0] start,
                                                 input logic [16:0] prog_in);
      int unsigned ssum, tsum, p, v;
      logic [31:0] fin, res;
      p = (prog_in > 17'h10000) ? 32'h10000 : 32'(prog_in);
      ssum = brightness(start);
      tsum = brightness(target_reg);
      fin = target_reg;
      if (limit_reg && ssum < tsum)
         for (int i = 0; i < 4; i++)
            fin[8*i +: 8] = 8'((target_reg[8*i +: 8] * ssum) / tsum);
      for (int i = 0; i < 4; i++) begin
         v = ((32'h10000 - p) * start[8*i +: 8] + p * fin[8*i +: 8]) >> 16;
         res[8*i +: 8] = v[7:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         target_reg <= '0;
         limit_reg  <= 1'b0;
         fail_count <= 0;
         pending_count <= 0;
         expected_colors.delete();
      end else begin
         // csr writes only happen while idle, so order within this step is safe
         if (req_tvalid && req_tready)
            expected_colors.push_back(predict_blend(req_tdata[31:0], req_tdata[48:32]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_colors.size() == 0) begin
               $error("unexpected transfer: blended_color actual %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               logic [31:0] exp_c;
               exp_c = expected_colors.pop_front();
               if (exp_c !== rsp_tdata) begin
                  $error("blended_color expected %h actual %h", exp_c, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_colors.size();
         if (csr_we) begin
            if (csr_index == rgbw_pkg::CsrTarget) target_reg <= csr_wdata;
            else if (csr_index == rgbw_pkg::CsrLimit) limit_reg <= csr_wdata[0];
         end
      end
   end
endmodule

// ===== test/tb_rgbw_fade_pixel_blender.sv =====
// Testbench top for the RGBW fade pixel blender: stimulus, csr phases and verdict.
// Depends on rgbw_pkg, rgbw_fade_pixel_blender and rgbw_blend_checker.
module tb_rgbw_fade_pixel_blender;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 0;
   logic [rgbw_pkg::CsrIdxW-1:0]  csr_index = '0;
   logic [rgbw_pkg::CsrDataW-1:0] csr_wdata = '0;
   int          fail_count, pending_count;
   int          cycle_count = 0;
   int          burst_left = 0;

   rgbw_fade_pixel_blender DUT (.*);
   rgbw_blend_checker checker_i (.*);

   initial forever #1 clock = ~clock;

   // receiver stall pattern: long open stretches, then random stalling
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count[9:8] == 2'b00) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
      if (cycle_count > 2000000) begin
         $display("tb_rgbw_fade_pixel_blender: FAIL");
         $finish;
      end
   end

   task automatic write_csr(input logic [rgbw_pkg::CsrIdxW-1:0] idx,
                            input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(input logic [31:0] start, input logic [16:0] prog_v);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 4)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, prog_v, start};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   function automatic logic [16:0] rand_progress();
      case ($urandom_range(0, 5))
         0: return 17'h10000;
         1: return 17'($urandom_range(17'h10001, 17'h1ffff));
         2: return 17'($urandom_range(0, 3));
         default: return 17'($urandom_range(0, 17'h10000));
      endcase
   endfunction

   initial begin
      logic [31:0] targets[6];
      targets = '{32'h00000000, 32'hffffffff, 32'h80402010, 32'h00ff0000, 32'h01000000, 32'h0};
      targets[5] = $urandom();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes with reset defaults, then limit mode on and then off on a bright target
      send_pixel(32'h0, 17'h0);
      send_pixel(32'hffffffff, 17'h0);
      send_pixel(32'hffffffff, 17'h10000);
      send_pixel(32'h12345678, 17'h1ffff);
      send_pixel(32'h00000000, 17'h08000);
      drain();
      write_csr(rgbw_pkg::CsrTarget, 32'hffffffff);
      write_csr(rgbw_pkg::CsrLimit, 32'h1);
      send_pixel(32'h00000000, 17'h10000);
      send_pixel(32'h01010101, 17'h10000);
      send_pixel(32'hffffffff, 17'h10000);
      send_pixel(32'h80808080, 17'h0c000);
      send_pixel(32'hfe000000, 17'h1ffff);
      send_pixel(32'h000000ff, 17'h0ffff);
      send_pixel(32'hffffff00, 17'h00001);
      drain();
      write_csr(rgbw_pkg::CsrLimit, 32'hfffffffe);
      send_pixel(32'h00000000, 17'h10000);
      send_pixel(32'h55aa55aa, 17'h08000);
      drain();
      // random phases across several target and mode settings
      for (int ph = 0; ph < 12; ph++) begin
         write_csr(rgbw_pkg::CsrTarget, (ph < 6) ? targets[ph] : $urandom());
         write_csr(rgbw_pkg::CsrLimit,
                   {$urandom_range(0, 1) ? 31'h0 : 31'h7fffffff, ph[0]});
         for (int i = 0; i < 160; i++)
            send_pixel($urandom_range(0, 3) == 0 ? {4{8'($urandom_range(0, 3) * 85)}}
                                                 : $urandom(), rand_progress());
         drain();
      end
      if (fail_count == 0) $display("tb_rgbw_fade_pixel_blender: PASS");
      else $display("tb_rgbw_fade_pixel_blender: FAIL");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/rgbw_pkg.sv
rtl/core/rgbw_divider.sv
rtl/core/rgbw_fade_pixel_blender.sv
test/rgbw_blend_checker.sv
test/tb_rgbw_fade_pixel_blender.sv
